/* sv/csrot_pkg.sv */
`timescale 1ns / 1ps

package csrot_pkg;

    // Fixed-point formats.
    localparam int FRAC_W  = 16;                  // fraction bits of every rounded value
    localparam int HALF    = 1 << (FRAC_W - 1);   // half LSB added before flooring
    localparam int COEF_W  = 18;                  // rotation entry, Q1.16
    localparam int DATA_W  = 32;                  // register and result width, Q15.16
    localparam int IDX_W   = 3;                   // Voigt index width
    localparam int ADDR_W  = 4;                   // APB byte address width
    localparam int VOIGT_N = 6;
    localparam int MAT_N   = 3;                   // rotation is MAT_N x MAT_N

    // Product chain widths.
    localparam int M1_W   = 2 * COEF_W;           // A[i]*A[j]
    localparam int T1_W   = M1_W - FRAC_W;        // rounded, |t1| <= 2^18
    localparam int M2_W   = T1_W + COEF_W;        // t1*A[k]
    localparam int T2_W   = T1_W + 1;             // rounded, |t2| <= 2^19
    localparam int M3_W   = T2_W + COEF_W;        // t2*A[l]
    localparam int TERM_W = T2_W + 1;             // rounded, |t3| <= 2^20
    localparam int SUM_W  = TERM_W + 1;           // sum of three terms
    localparam int AL_W   = DATA_W + 2;           // c11 - c12 - 2*c44
    localparam int PROD_W = AL_W + SUM_W;         // al * sum
    localparam int SCL_W  = PROD_W - FRAC_W;      // rounded scaled term
    localparam int H_W    = DATA_W + 2;           // c12 + 2*c44
    localparam int TOT_W  = SCL_W + 1;            // entry before saturation

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(VOIGT_N - 1);

    // Register indexes (byte address / 4).
    localparam logic [1:0] REG_C11 = 2'd0;
    localparam logic [1:0] REG_C12 = 2'd1;
    localparam logic [1:0] REG_C44 = 2'd2;

    typedef logic signed [COEF_W-1:0] t_coef;

    // Operands of one column of the product chain.
    typedef struct packed {
        t_coef ai;
        t_coef aj;
        t_coef ak;
        t_coef al;
    } t_lane_ops;

    // Control that travels down the pipeline beside the data.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] p;
        logic [IDX_W-1:0] q;
        logic             last;
        logic             use_c12;
        logic [1:0]       n_c44;
    } t_tag;

    typedef struct packed {
        logic signed [DATA_W-1:0] c11;
        logic signed [DATA_W-1:0] c12;
        logic signed [DATA_W-1:0] c44;
    } t_cfg;

    // First tensor index of a Voigt index.
    function automatic logic [1:0] pair_a(input logic [IDX_W-1:0] v);
        logic [1:0] res;
        unique case (v)
            3'd0:    res = 2'd0;
            3'd1:    res = 2'd1;
            3'd2:    res = 2'd2;
            3'd3:    res = 2'd1;
            3'd4:    res = 2'd0;
            3'd5:    res = 2'd0;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    // Second tensor index of a Voigt index.
    function automatic logic [1:0] pair_b(input logic [IDX_W-1:0] v);
        logic [1:0] res;
        unique case (v)
            3'd0:    res = 2'd0;
            3'd1:    res = 2'd1;
            3'd2:    res = 2'd2;
            3'd3:    res = 2'd2;
            3'd4:    res = 2'd2;
            3'd5:    res = 2'd1;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

endpackage

/* sv/csrot_apb.sv */
`timescale 1ns / 1ps

module csrot_apb import csrot_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_C11: r_cfg.c11 <= pwdata;
                REG_C12: r_cfg.c12 <= pwdata;
                REG_C44: r_cfg.c44 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_C11: prdata = r_cfg.c11;
            REG_C12: prdata = r_cfg.c12;
            REG_C44: prdata = r_cfg.c44;
            default: prdata = '0;
        endcase
    end

endmodule

/* sv/csrot_seq.sv */
`timescale 1ns / 1ps

module csrot_seq import csrot_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [MAT_N*MAT_N-1:0][COEF_W-1:0] i_mat,
    output t_tag                          o_tag,
    output t_lane_ops [MAT_N-1:0]         o_ops
);

    logic                              r_busy, n_busy;
    logic [IDX_W-1:0]                  r_p, n_p;
    logic [IDX_W-1:0]                  r_q, n_q;
    logic [MAT_N*MAT_N-1:0][COEF_W-1:0] r_mat, n_mat;
    t_tag                              r_tag, n_tag;
    t_lane_ops [MAT_N-1:0]             r_ops, n_ops;
    logic                              last_issue;
    logic [1:0]                        pi, pj, pk, pl;

    assign o_tag = r_tag;
    assign o_ops = r_ops;

    always_comb begin
        n_busy = r_busy;
        n_p    = r_p;
        n_q    = r_q;
        n_mat  = r_mat;
        n_tag  = r_tag;
        n_ops  = r_ops;
        pi     = pair_a(r_p);
        pj     = pair_b(r_p);
        pk     = pair_a(r_q);
        pl     = pair_b(r_q);

        last_issue = r_busy && (r_p == IDX_LAST) && (r_q == IDX_LAST);
        o_ready    = i_adv && (!r_busy || last_issue);

        if (i_adv) begin
            n_tag.valid   = r_busy;
            n_tag.p       = r_p;
            n_tag.q       = r_q;
            n_tag.last    = last_issue;
            n_tag.use_c12 = (pi == pj) && (pk == pl);
            n_tag.n_c44   = 2'((pi == pk) && (pj == pl)) + 2'((pi == pl) && (pj == pk));
            for (int r = 0; r < MAT_N; r++) begin
                n_ops[r].ai = r_mat[4'(pi) * 4'(MAT_N) + 4'(r)];
                n_ops[r].aj = r_mat[4'(pj) * 4'(MAT_N) + 4'(r)];
                n_ops[r].ak = r_mat[4'(pk) * 4'(MAT_N) + 4'(r)];
                n_ops[r].al = r_mat[4'(pl) * 4'(MAT_N) + 4'(r)];
            end
            if (r_busy) begin
                if (r_q == IDX_LAST) begin
                    n_q = '0;
                    n_p = r_p + 1'b1;
                end else begin
                    n_q = r_q + 1'b1;
                end
            end
            if (o_ready) begin
                n_busy = i_valid;
                n_p    = '0;
                n_q    = '0;
                if (i_valid) begin
                    n_mat = i_mat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_p    <= '0;
            r_q    <= '0;
            r_tag  <= '0;
        end else begin
            r_busy <= n_busy;
            r_p    <= n_p;
            r_q    <= n_q;
            r_tag  <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
        r_ops <= n_ops;
    end

endmodule

/* sv/csrot_lane.sv */
`timescale 1ns / 1ps

module csrot_lane import csrot_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_adv,
    input  t_lane_ops                i_ops,
    output logic signed [TERM_W-1:0] o_term
);

    // Three multiply stages; each rounds the previous product to 16
    // fraction bits (add half, floor) before the next multiply.
    logic signed [M1_W-1:0] r_m1;
    t_coef                  r_ak1;
    t_coef                  r_al1;
    logic signed [M2_W-1:0] r_m2;
    t_coef                  r_al2;
    logic signed [M3_W-1:0] r_m3;

    logic signed [M1_W-1:0] s1;
    logic signed [T1_W-1:0] t1;
    logic signed [M2_W-1:0] s2;
    logic signed [T2_W-1:0] t2;
    logic signed [M3_W-1:0] s3;

    always_comb begin
        s1     = r_m1 + M1_W'(HALF);
        t1     = s1[FRAC_W+T1_W-1:FRAC_W];
        s2     = r_m2 + M2_W'(HALF);
        t2     = s2[FRAC_W+T2_W-1:FRAC_W];
        s3     = r_m3 + M3_W'(HALF);
        o_term = s3[FRAC_W+TERM_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m1  <= i_ops.ai * i_ops.aj;
            r_ak1 <= i_ops.ak;
            r_al1 <= i_ops.al;
            r_m2  <= t1 * r_ak1;
            r_al2 <= r_al1;
            r_m3  <= t2 * r_al2;
        end
    end

endmodule

/* sv/cubic_stiffness_rotation.sv */
`timescale 1ns / 1ps
// The first entry of a matrix is shown after it has passed the issue stage and the datapath.
// Throughput: one stiffness entry per cycle while the output is not stalled, back to back.
// The 36-entry issue counter sets the rate; the 8 stages take an entry each unstalled cycle.
// Reset (i_rst_n low at a clock edge) clears c11, c12, c44 to zero and empties the pipeline.

module cubic_stiffness_rotation import csrot_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    // Rotation request.
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [COEF_W-1:0] i_r00,
    input  logic signed [COEF_W-1:0] i_r01,
    input  logic signed [COEF_W-1:0] i_r02,
    input  logic signed [COEF_W-1:0] i_r10,
    input  logic signed [COEF_W-1:0] i_r11,
    input  logic signed [COEF_W-1:0] i_r12,
    input  logic signed [COEF_W-1:0] i_r20,
    input  logic signed [COEF_W-1:0] i_r21,
    input  logic signed [COEF_W-1:0] i_r22,
    // Stiffness entries.
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [IDX_W-1:0]         o_row_index,
    output logic [IDX_W-1:0]         o_col_index,
    output logic signed [DATA_W-1:0] o_stiffness,
    output logic                     o_last
);

    // The whole pipeline moves together. It holds only while the output
    // register carries an entry that the consumer has not taken yet, so a
    // stall neither drops nor repeats anything.
    logic adv;

    t_cfg                  w_cfg;
    t_tag                  w_tag1;
    t_lane_ops [MAT_N-1:0] w_ops;
    logic signed [TERM_W-1:0] w_term [MAT_N];

    // Control tags for stages two to eight, aligned with the datapath.
    t_tag r_tag2, r_tag3, r_tag4, r_tag5, r_tag6, r_tag7, r_tag8;

    logic signed [AL_W-1:0]   r_al;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [H_W-1:0]    r_h;
    logic signed [TOT_W-1:0]  r_tot;
    logic signed [DATA_W-1:0] r_stiff;

    logic signed [SUM_W-1:0]  n_sum;
    logic signed [H_W-1:0]    n_h;
    logic signed [PROD_W-1:0] rnd_prod;
    logic signed [SCL_W-1:0]  scaled;
    logic signed [TOT_W-1:0]  n_tot;
    logic signed [DATA_W-1:0] n_stiff;

    assign adv = !r_tag8.valid || i_ready;

    csrot_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Stage one: the request register and the issue counter. It walks the
    // 36 Voigt pairs row-major and picks the four rotation entries of each
    // column for the three product lanes. The next request is taken in the
    // same cycle that the last pair of the current one is issued.
    csrot_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mat   ({i_r22, i_r21, i_r20, i_r12, i_r11, i_r10, i_r02, i_r01, i_r00}),
        .o_tag   (w_tag1),
        .o_ops   (w_ops)
    );

    // Stages two to four: one lane per rotation column forms the rounded
    // product A[i][r]*A[j][r]*A[k][r]*A[l][r].
    for (genvar g = 0; g < MAT_N; g++) begin : g_lane
        csrot_lane u_lane (
            .i_clk  (i_clk),
            .i_adv  (adv),
            .i_ops  (w_ops[g]),
            .o_term (w_term[g])
        );
    end

    always_comb begin
        // Stage five input: exact sum of the three column terms.
        n_sum = SUM_W'(w_term[0]) + SUM_W'(w_term[1]) + SUM_W'(w_term[2]);

        // The isotropic part: c12 where both pairs are normal, plus c44 once
        // for each way the two tensor index pairs match.
        n_h = r_tag5.use_c12 ? H_W'(w_cfg.c12) : '0;
        case (r_tag5.n_c44)
            2'd1:    n_h = n_h + H_W'(w_cfg.c44);
            2'd2:    n_h = n_h + (H_W'(w_cfg.c44) <<< 1);
            default: ;
        endcase

        // Stage seven input: round the anisotropy term and add the rest.
        rnd_prod = r_prod + PROD_W'(HALF);
        scaled   = rnd_prod[FRAC_W+SCL_W-1:FRAC_W];
        n_tot    = TOT_W'(scaled) + TOT_W'(r_h);

        // Stage eight input: saturate to the 32-bit result range.
        if ((r_tot[TOT_W-1:DATA_W-1] == '0) || (r_tot[TOT_W-1:DATA_W-1] == '1)) begin
            n_stiff = r_tot[DATA_W-1:0];
        end else if (r_tot[TOT_W-1]) begin
            n_stiff = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            n_stiff = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            r_tag5 <= '0;
            r_tag6 <= '0;
            r_tag7 <= '0;
            r_tag8 <= '0;
        end else if (adv) begin
            r_tag2 <= w_tag1;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            r_tag5 <= r_tag4;
            r_tag6 <= r_tag5;
            r_tag7 <= r_tag6;
            r_tag8 <= r_tag7;
        end
    end

    // The anisotropy factor is registered from the configuration registers.
    // The user must change configuration only while the block is idle; the block does not
    // enforce it. An entry passes stages one to five before the multiplier, so r_al has settled.
    always_ff @(posedge i_clk) begin
        r_al <= AL_W'(w_cfg.c11) - AL_W'(w_cfg.c12) - (AL_W'(w_cfg.c44) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum   <= n_sum;
            r_prod  <= r_al * r_sum;
            r_h     <= n_h;
            r_tot   <= n_tot;
            r_stiff <= n_stiff;
        end
    end

    assign o_valid     = r_tag8.valid;
    assign o_row_index = r_tag8.p;
    assign o_col_index = r_tag8.q;
    assign o_last      = r_tag8.last;
    assign o_stiffness = r_stiff;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import csrot_pkg::*;

    // Clock, reset and run-length settings.
    localparam int RESET_CYCLES = 4;
    localparam int PIPE_LATENCY = 8;          // request accepted to first entry shown
    localparam int TIMEOUT_NS   = 1_000_000;  // far beyond the slowest correct run
    localparam int MAX_PRINTED  = 40;         // error lines printed before going quiet

    // Register index past the end of the map; writes to it must change nothing.
    localparam logic [1:0] REG_SPARE = 2'd3;

    // Handy Q1.16 values for the rotation entries.
    localparam int ONE      = 1 << FRAC_W;
    localparam int COEF_MAX = (1 << (COEF_W - 1)) - 1;
    localparam int COEF_MIN = -(1 << (COEF_W - 1));

    // Extremes of the Q15.16 constants.
    localparam logic [DATA_W-1:0] CONST_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] CONST_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    // Saturation bounds of a stiffness entry, held in 64 bits.
    localparam longint STIFF_MAX = (longint'(1) << (DATA_W - 1)) - 1;
    localparam longint STIFF_MIN = -(longint'(1) << (DATA_W - 1));

    // A whole rotation request packed flat: entry (row, col) sits at slot row*3+col.
    typedef logic [MAT_N*MAT_N*COEF_W-1:0] t_rot;

    // One stiffness entry as the block should present it.
    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] stiffness;
        logic                     last;
    } t_entry;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    t_coef                    i_r00 = '0;
    t_coef                    i_r01 = '0;
    t_coef                    i_r02 = '0;
    t_coef                    i_r10 = '0;
    t_coef                    i_r11 = '0;
    t_coef                    i_r12 = '0;
    t_coef                    i_r20 = '0;
    t_coef                    i_r21 = '0;
    t_coef                    i_r22 = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [IDX_W-1:0]         o_row_index;
    logic [IDX_W-1:0]         o_col_index;
    logic signed [DATA_W-1:0] o_stiffness;
    logic                     o_last;

    // Our copy of the cubic constants, updated whenever a register write lands.
    logic signed [DATA_W-1:0] cfg_c11 = '0;
    logic signed [DATA_W-1:0] cfg_c12 = '0;
    logic signed [DATA_W-1:0] cfg_c44 = '0;

    // Tensor index pair behind each Voigt index: xx, yy, zz, yz, xz, xy.
    int voigt_first  [VOIGT_N] = '{0, 1, 2, 1, 0, 0};
    int voigt_second [VOIGT_N] = '{0, 1, 2, 2, 2, 1};

    // Entries predicted for accepted requests, oldest at the front.
    t_entry pending_entries [$];

    // Idle rates in percent per cycle, and the length of a forced receiver hold-off.
    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int sink_hold_left = 0;
    int fail_count     = 0;

    cubic_stiffness_rotation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_r00       (i_r00),
        .i_r01       (i_r01),
        .i_r02       (i_r02),
        .i_r10       (i_r10),
        .i_r11       (i_r11),
        .i_r12       (i_r12),
        .i_r20       (i_r20),
        .i_r21       (i_r21),
        .i_r22       (i_r22),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_row_index (o_row_index),
        .o_col_index (o_col_index),
        .o_stiffness (o_stiffness),
        .o_last      (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops entries.
    initial begin
        #TIMEOUT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        fail_count++;
    endtask

    // Add half an LSB and floor, so that ties round toward plus infinity.
    function automatic longint round_q16(input longint x);
        return (x + HALF) >>> FRAC_W;
    endfunction

    // Works out all 36 entries of the rotated stiffness matrix for one rotation,
    // row-major, and queues them for the checker. Every product is rounded
    // back to 16 fraction bits before the next factor comes in; the column sum
    // is exact, and only the final total saturates.
    function automatic void predict_rotated_stiffness(input t_rot rot);
        longint a [MAT_N][MAT_N];
        longint aniso;
        longint col_sum;
        longint term;
        longint total;
        t_coef  coef;
        int     i, j, k, l;
        t_entry e;
        for (int n = 0; n < MAT_N * MAT_N; n++) begin
            coef = rot[n*COEF_W +: COEF_W];
            a[n / MAT_N][n % MAT_N] = coef;
        end
        // The anisotropy factor needs up to 34 bits, so it is kept in 64.
        aniso = longint'(cfg_c11) - longint'(cfg_c12) - 2 * longint'(cfg_c44);
        for (int p = 0; p < VOIGT_N; p++) begin
            i = voigt_first[p];
            j = voigt_second[p];
            for (int q = 0; q < VOIGT_N; q++) begin
                k = voigt_first[q];
                l = voigt_second[q];
                col_sum = 0;
                for (int r = 0; r < MAT_N; r++) begin
                    term = round_q16(a[i][r] * a[j][r]);
                    term = round_q16(term * a[k][r]);
                    term = round_q16(term * a[l][r]);
                    col_sum += term;
                end
                total = round_q16(aniso * col_sum);
                if (i == j && k == l) total += cfg_c12;
                if (i == k && j == l) total += cfg_c44;
                if (i == l && j == k) total += cfg_c44;
                if (total > STIFF_MAX) total = STIFF_MAX;
                if (total < STIFF_MIN) total = STIFF_MIN;
                e.row       = IDX_W'(p);
                e.col       = IDX_W'(q);
                e.stiffness = DATA_W'(total);
                e.last      = (p == VOIGT_N - 1) && (q == VOIGT_N - 1);
                pending_entries.insert(pending_entries.size(), e);
            end
        end
    endfunction

    function automatic t_rot rot_of(input int m00, m01, m02, m10, m11, m12,
                                    m20, m21, m22);
        return {t_coef'(m22), t_coef'(m21), t_coef'(m20),
                t_coef'(m12), t_coef'(m11), t_coef'(m10),
                t_coef'(m02), t_coef'(m01), t_coef'(m00)};
    endfunction

    // A genuine rotation Rz(a)*Rx(b), with its rows cycled and sign-flipped at
    // random so that all three axes and both orientations get exercised.
    function automatic t_rot random_rotation();
        real  ang_a, ang_b, ca, sa, cb, sb, scale;
        real  m [MAT_N][MAT_N];
        int   shift, row;
        t_rot r;
        ang_a = $urandom_range(0, 62831) / 10000.0;
        ang_b = $urandom_range(0, 62831) / 10000.0;
        ca = $cos(ang_a);
        sa = $sin(ang_a);
        cb = $cos(ang_b);
        sb = $sin(ang_b);
        m[0][0] = ca;  m[0][1] = -sa * cb; m[0][2] = sa * sb;
        m[1][0] = sa;  m[1][1] = ca * cb;  m[1][2] = -ca * sb;
        m[2][0] = 0.0; m[2][1] = sb;       m[2][2] = cb;
        shift = $urandom_range(0, MAT_N - 1);
        for (int p = 0; p < MAT_N; p++) begin
            row   = (p + shift) % MAT_N;
            scale = ($urandom_range(0, 1) == 1) ? -65536.0 : 65536.0;
            for (int q = 0; q < MAT_N; q++) begin
                r[(row*MAT_N + q)*COEF_W +: COEF_W] = t_coef'($rtoi(m[p][q] * scale));
            end
        end
        return r;
    endfunction

    // Independent random entries in [lo, hi]; no validity is implied.
    function automatic t_rot random_entries(input int lo, input int hi);
        t_rot r;
        for (int n = 0; n < MAT_N * MAT_N; n++) begin
            r[n*COEF_W +: COEF_W] = t_coef'(lo + int'($urandom_range(0, hi - lo)));
        end
        return r;
    endfunction

    // Mostly proper rotations, then unit-range noise, then any 18-bit pattern.
    function automatic t_rot random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return random_rotation();
        if (pick < 85) return random_entries(-ONE, ONE);
        return random_entries(COEF_MIN, COEF_MAX);
    endfunction

    // APB write. The transfer is left open so that a following transfer can
    // start in the same cycle; apb_release closes the bus.
    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_C11: cfg_c11 = value;
            REG_C12: cfg_c12 = value;
            REG_C44: cfg_c44 = value;
            default: ;
        endcase
    endtask

    task automatic apb_read(input logic [1:0] idx, output logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reads all three constants back and compares them with our copy.
    task automatic check_constants();
        logic [DATA_W-1:0] got;
        apb_read(REG_C11, got);
        if (got !== cfg_c11) report_error($sformatf("c11 reads %h, expected %h", got, cfg_c11));
        apb_read(REG_C12, got);
        if (got !== cfg_c12) report_error($sformatf("c12 reads %h, expected %h", got, cfg_c12));
        apb_read(REG_C44, got);
        if (got !== cfg_c44) report_error($sformatf("c44 reads %h, expected %h", got, cfg_c44));
    endtask

    // Only called while the block is idle.
    task automatic load_constants(input logic [DATA_W-1:0] c11, c12, c44);
        apb_write(REG_C11, c11);
        apb_write(REG_C12, c12);
        apb_write(REG_C44, c44);
        check_constants();
        apb_release();
    endtask

    // Offers one rotation request, after a random idle gap, and holds it until
    // the block takes it. Valid stays high afterward so that a following
    // request can go out in the very next cycle.
    task automatic send_rotation(input t_rot rot);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_r00   <= rot[0*COEF_W +: COEF_W];
        i_r01   <= rot[1*COEF_W +: COEF_W];
        i_r02   <= rot[2*COEF_W +: COEF_W];
        i_r10   <= rot[3*COEF_W +: COEF_W];
        i_r11   <= rot[4*COEF_W +: COEF_W];
        i_r12   <= rot[5*COEF_W +: COEF_W];
        i_r20   <= rot[6*COEF_W +: COEF_W];
        i_r21   <= rot[7*COEF_W +: COEF_W];
        i_r22   <= rot[8*COEF_W +: COEF_W];
        do @(posedge i_clk); while (!o_ready);
        predict_rotated_stiffness(rot);
    endtask

    // Drops valid and waits until every predicted entry has come out, plus the
    // pipeline latency and a margin, so that anything stray would still show up.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    // Constants must read zero after reset, and an identity then yields an
    // all-zero matrix.
    task automatic test_reset_constants();
        check_constants();
        apb_release();
        send_rotation(rot_of(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_rotation(random_request());
        wait_drained();
    endtask

    // Hand-picked rotations under realistic constants: identity, inversion,
    // signed permutation, 45 and 30 degree turns, the field extremes,
    // alternating bit patterns, zero, and products that land exactly on a
    // rounding tie.
    task automatic test_directed_matrices();
        load_constants(32'd11036262, 32'd7956070, 32'd4941414);
        send_rotation(rot_of(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_rotation(rot_of(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        send_rotation(rot_of(0, ONE, 0, 0, 0, -ONE, -ONE, 0, 0));
        send_rotation(rot_of(46341, -46341, 0, 46341, 46341, 0, 0, 0, ONE));
        send_rotation(rot_of(ONE, 0, 0, 0, 56756, -32768, 0, 32768, 56756));
        send_rotation(rot_of(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                             COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
        send_rotation(rot_of(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                             COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
        send_rotation(rot_of(87381, -87382, 87381, -87382, 87381, -87382,
                             87381, -87382, 87381));
        send_rotation(rot_of(-87382, 87381, -87382, 87381, -87382, 87381,
                             -87382, 87381, -87382));
        send_rotation(rot_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_rotation(rot_of(128, 256, -128, 256, -128, 384, -128, 384, 256));
        wait_drained();
    endtask

    // A write past the register map must leave the constants alone.
    task automatic test_spare_register();
        apb_write(REG_SPARE, $urandom());
        check_constants();
        apb_release();
        send_rotation(rot_of(46341, -46341, 0, 46341, 46341, 0, 0, 0, ONE));
        wait_drained();
    endtask

    // Constants at opposite extremes push the anisotropy factor to its
    // largest magnitude, so large matrices saturate both ways.
    task automatic test_extreme_constants();
        load_constants(CONST_MAX, CONST_MIN, CONST_MIN);
        send_rotation(rot_of(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX,
                             COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
        send_rotation(rot_of(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        send_rotation(rot_of(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                             COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
        wait_drained();
        load_constants(CONST_MIN, CONST_MAX, CONST_MAX);
        send_rotation(rot_of(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX,
                             COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX));
        send_rotation(rot_of(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE));
        send_rotation(rot_of(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN,
                             COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
        wait_drained();
    endtask

    // The receiver stops for a long stretch while requests keep coming back
    // to back, so the pipeline fills and the block has to stall its input.
    // The sender then pauses until the whole backlog has drained.
    task automatic test_backpressure();
        int saved_idle;
        saved_idle     = src_idle_pct;
        src_idle_pct   = 0;
        sink_hold_left = 400;
        repeat (10) send_rotation(random_request());
        wait_drained();
        src_idle_pct = saved_idle;
    endtask

    // One idle mode, two settings of the constants: a realistic material,
    // then arbitrary 32-bit values.
    task automatic test_random_phase(input int src_pct, input int sink_pct);
        logic [DATA_W-1:0] k11, k12, k44;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        k11 = ($urandom_range(100, 300) << FRAC_W) | $urandom_range(0, ONE - 1);
        k12 = ($urandom_range(50, 200) << FRAC_W) | $urandom_range(0, ONE - 1);
        k44 = ($urandom_range(20, 150) << FRAC_W) | $urandom_range(0, ONE - 1);
        load_constants(k11, k12, k44);
        repeat (25) send_rotation(random_request());
        wait_drained();
        load_constants($urandom(), $urandom(), $urandom());
        repeat (25) send_rotation(random_request());
        wait_drained();
    endtask

    // Result side: every entry taken is checked against the oldest
    // prediction, then ready for the next cycle is chosen, honoring any
    // hold-off that a test has asked for.
    initial begin
        t_entry want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_entries.size() == 0) begin
                    report_error($sformatf("unexpected entry row %0d col %0d value %0d",
                                           o_row_index, o_col_index, o_stiffness));
                end else begin
                    want = pending_entries.pop_front();
                    if (o_row_index !== want.row)
                        report_error($sformatf("row index %0d, expected %0d",
                                               o_row_index, want.row));
                    if (o_col_index !== want.col)
                        report_error($sformatf("col index %0d, expected %0d",
                                               o_col_index, want.col));
                    if (o_stiffness !== want.stiffness)
                        report_error($sformatf("entry (%0d,%0d) is %0d, expected %0d",
                                               want.row, want.col, o_stiffness,
                                               want.stiffness));
                    if (o_last !== want.last)
                        report_error($sformatf("last flag %b on (%0d,%0d), expected %b",
                                               o_last, want.row, want.col, want.last));
                end
            end
            if (sink_hold_left > 0) begin
                sink_hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Main sequence. Reset is held low at the start, then the directed tests
    // run with a slow receiver, and the random phases walk through the three
    // idle modes: slow receiver, slow sender, and no idling at all.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle_pct  = 21;
        sink_idle_pct = 83;
        test_reset_constants();
        test_directed_matrices();
        test_spare_register();
        test_extreme_constants();
        test_backpressure();
        test_random_phase(21, 83);
        test_random_phase(83, 21);
        test_random_phase(0, 0);
        wait_drained();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/csrot_pkg.sv
sv/csrot_apb.sv
sv/csrot_seq.sv
sv/csrot_lane.sv
sv/cubic_stiffness_rotation.sv
sim/testbench.sv
